// ===== hw/rtl/vector_alu_register_device_core_assert.svh =====
// Assertion macros shared by the vector ALU register device RTL.
// Depends on nothing; included by modules that check their own logic.
`ifndef VECTOR_ALU_REGISTER_DEVICE_CORE_ASSERT_SVH
`define VECTOR_ALU_REGISTER_DEVICE_CORE_ASSERT_SVH
// Checks a property on every rising clock edge while out of reset.
`define VARD_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Checks a property on every rising clock edge, reset included.
`define VARD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== hw/rtl/vard_pkg.sv =====
// Package for the vector ALU register device: widths, codes, addresses and types.
// Depends on nothing; used by every module of the block.
package vard_pkg;
    localparam int WORDS = 16;
    localparam int IDX_W = 4;
    localparam int VECTOR_LENGTH = 16;
    localparam logic [11:0] BASE_A = 12'h004;
    localparam logic [11:0] BASE_B = 12'h044;
    localparam logic [11:0] BASE_C = 12'h084;
    localparam logic [11:0] END_C = 12'h0C4;
    localparam logic [3:0] MAX_BYTES = 4'd4;

    typedef enum logic [2:0] {
        ST_OK = 3'd0,
        ST_BYTE_ENABLE = 3'd1,
        ST_BURST = 3'd2,
        ST_ADDRESS = 3'd3,
        ST_COMMAND = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_ADD = 3'd1,
        OP_SUB = 3'd2,
        OP_MUL = 3'd3,
        OP_DIV = 3'd4,
        OP_MAC = 3'd5
    } opcode_t;

    localparam logic [1:0] REQ_READ = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;

    typedef enum logic [2:0] {
        K_NOP = 3'd0,
        K_RD_CTRL = 3'd1,
        K_RD_VEC = 3'd2,
        K_WR_CTRL = 3'd3,
        K_WR_VEC = 3'd4,
        K_RUN = 3'd5
    } kind_t;

    // One classified access passed from the front part to the back part.
    typedef struct packed {
        kind_t kind;
        status_t status;
        logic [1:0] vsel;
        logic [IDX_W-1:0] idx;
        logic [31:0] wdata;
        logic [3:0] len;
        opcode_t op;
    } cmd_t;

    localparam int QDEPTH = 2;
endpackage

// ===== hw/rtl/vector_alu_register_device_core.sv =====
// Path: a register access passes the queue, then the result register; a vector
// opcode write runs its 16 elements through S_ELEM and S_DIV, divide waiting on the
// one-bit-a-cycle divider. Throughput: one access per cycle into a two-entry queue
// while not full, one served per cycle when the output is free and no opcode runs.
// Reset: synchronous, active low; clears vectors, control word, queue and output valid.
// Top level; depends on vard_pkg, vard_front and vard_back.
module vector_alu_register_device_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata: req_type[1:0], address[13:2], write_data[45:14], access_length[49:46],
    // stream_width[53:50], byte_enables_used[54], zero fill [55].
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata: read_data[31:0], status[34:32], zero fill [39:35].
    output logic [39:0] m_tdata
);
    import vard_pkg::*;

    logic q_valid, q_pop;
    cmd_t q_head;
    logic [31:0] rd;
    logic [2:0] st;

    vard_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .req_type(s_tdata[1:0]), .address(s_tdata[13:2]), .write_data(s_tdata[45:14]),
        .access_length(s_tdata[49:46]), .stream_width(s_tdata[53:50]),
        .byte_enables_used(s_tdata[54]),
        .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head)
    );

    vard_back u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid), .q_pop(q_pop),
        .q_head(q_head), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .read_data(rd), .status(st)
    );

    assign m_tdata = {5'd0, st, rd};
endmodule

// ===== hw/rtl/vard_front.sv =====
// Front part: accepts bus accesses, runs the error checks and decodes the address.
// Depends on vard_pkg; feeds a two-entry command queue.
module vard_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [1:0]    req_type,
    input  logic [11:0]   address,
    input  logic [31:0]   write_data,
    input  logic [3:0]    access_length,
    input  logic [3:0]    stream_width,
    input  logic          byte_enables_used,
    output logic          q_valid,
    input  logic          q_pop,
    output vard_pkg::cmd_t q_head
);
    import vard_pkg::*;
    `include "vector_alu_register_device_core_assert.svh"

    cmd_t q_reg [QDEPTH];
    logic [0:0] wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    cmd_t c;
    logic [11:0] off;
    logic push;

    always_comb begin
        c = '0;
        c.kind = K_NOP;
        c.status = ST_OK;
        c.op = OP_NONE;
        c.wdata = write_data;
        c.len = access_length;
        off = 12'd0;
        if (address >= BASE_C) begin
            c.vsel = 2'd2;
            off = address - BASE_C;
        end else if (address >= BASE_B) begin
            c.vsel = 2'd1;
            off = address - BASE_B;
        end else begin
            c.vsel = 2'd0;
            off = address - BASE_A;
        end
        c.idx = off[IDX_W+1:2];
        if (byte_enables_used) begin
            c.status = ST_BYTE_ENABLE;
        end else if (access_length > MAX_BYTES || stream_width < access_length) begin
            c.status = ST_BURST;
        end else if (req_type == REQ_READ || req_type == REQ_WRITE) begin
            if (address >= END_C || (address != 12'd0 && address < BASE_A)) begin
                c.status = ST_ADDRESS;
            end else if (address == 12'd0) begin
                if (req_type == REQ_READ) begin
                    c.kind = K_RD_CTRL;
                end else if (write_data >= 32'd1 && write_data <= 32'(OP_MAC)) begin
                    c.kind = K_RUN;
                    c.op = opcode_t'(write_data[2:0]);
                end else begin
                    c.kind = K_WR_CTRL;
                end
            end else begin
                c.kind = (req_type == REQ_READ) ? K_RD_VEC : K_WR_VEC;
            end
        end else begin
            c.status = ST_COMMAND;
        end
    end

    assign s_tready = (cnt_reg != 2'(QDEPTH));
    assign push = s_tvalid && s_tready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_head = q_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wp_reg] <= c;
        end
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (q_pop) begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop);
        end
    end

    `VARD_ASSERT(a_no_overflow, aclk, aresetn, cnt_reg <= 2'(QDEPTH), "queue overflow")
    `VARD_ASSERT(a_pop_valid, aclk, aresetn, !q_pop || q_valid, "pop from empty queue")
    `VARD_ASSERT(a_full_stall, aclk, aresetn, (cnt_reg == 2'(QDEPTH)) |-> !s_tready, "full not stalled")
endmodule

// ===== hw/rtl/vard_div.sv =====
// Iterative 32-bit unsigned divider, one quotient bit per cycle.
// Depends on vard_pkg only through the import convention; used by the back part.
module vard_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);
    import vard_pkg::*;

    logic        busy_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] q_reg, d_reg;
    logic [32:0] r_reg;
    logic [32:0] sh;
    logic        ge;

    assign sh = {r_reg[31:0], q_reg[31]};
    assign ge = sh >= {1'b0, d_reg};
    assign quotient = q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done <= 1'b0;
            cnt_reg <= '0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg <= 6'd32;
                q_reg <= dividend;
                d_reg <= divisor;
                r_reg <= '0;
            end else if (busy_reg) begin
                r_reg <= ge ? sh - {1'b0, d_reg} : sh;
                q_reg <= {q_reg[30:0], ge};
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done <= 1'b1;
                end
            end
        end
    end
endmodule

// ===== hw/rtl/vard_back.sv =====
// Back part: holds the vectors and control word, serves accesses and runs vector ops.
// Depends on vard_pkg and vard_div; takes commands from the front queue.
module vard_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    output logic           q_pop,
    input  vard_pkg::cmd_t q_head,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [31:0]    read_data,
    output logic [2:0]     status
);
    import vard_pkg::*;
    `include "vector_alu_register_device_core_assert.svh"

    typedef enum logic [1:0] { S_IDLE, S_ELEM, S_DIV, S_DONE } state_t;

    state_t state_reg;
    logic [31:0] va_reg [WORDS];
    logic [31:0] vb_reg [WORDS];
    logic [31:0] vc_reg [WORDS];
    logic [31:0] ctrl_reg;
    logic [IDX_W-1:0] i_reg;
    logic [31:0] prod_reg;
    logic [31:0] rdata_next, v, mask;
    logic [31:0] a_el, b_el, c_el, res;
    logic div_start, div_done;
    logic [31:0] div_q;
    logic last;
    logic out_free;

    assign out_free = !m_tvalid || m_tready;
    assign a_el = va_reg[i_reg];
    assign b_el = vb_reg[i_reg];
    assign c_el = vc_reg[i_reg];
    assign last = (i_reg == IDX_W'(VECTOR_LENGTH - 1));
    assign div_start = (state_reg == S_ELEM) && q_head.op == OP_DIV && b_el != 32'd0;

    vard_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(a_el), .divisor(b_el), .done(div_done), .quotient(div_q)
    );

    always_comb begin
        case (q_head.vsel)
            2'd0: v = va_reg[q_head.idx];
            2'd1: v = vb_reg[q_head.idx];
            default: v = vc_reg[q_head.idx];
        endcase
        if (q_head.kind == K_RD_CTRL) begin
            v = ctrl_reg;
        end
        mask = (q_head.len >= MAX_BYTES) ? 32'hFFFF_FFFF
             : ((32'd1 << {q_head.len[1:0], 3'b000}) - 32'd1);
        rdata_next = (q_head.kind == K_RD_CTRL || q_head.kind == K_RD_VEC) ? (v & mask) : 32'd0;
        case (q_head.op)
            OP_ADD: res = a_el + b_el;
            OP_SUB: res = a_el - b_el;
            OP_MUL: res = prod_reg;
            OP_MAC: res = c_el + prod_reg;
            default: res = 32'd0;
        endcase
    end

    assign q_pop = q_valid && out_free &&
                   ((state_reg == S_IDLE && q_head.kind != K_RUN) || state_reg == S_DONE);

    always_ff @(posedge aclk) begin
        prod_reg <= a_el * b_el;
        if (!aresetn) begin
            state_reg <= S_IDLE;
            m_tvalid <= 1'b0;
            ctrl_reg <= '0;
            i_reg <= '0;
            for (int k = 0; k < WORDS; k++) begin
                va_reg[k] <= '0;
                vb_reg[k] <= '0;
                vc_reg[k] <= '0;
            end
        end else begin
            if (q_pop) begin
                m_tvalid <= 1'b1;
                read_data <= rdata_next;
                status <= q_head.status;
                if (q_head.kind == K_WR_CTRL) begin
                    ctrl_reg <= q_head.wdata;
                end
                if (q_head.kind == K_WR_VEC) begin
                    case (q_head.vsel)
                        2'd0: va_reg[q_head.idx] <= q_head.wdata;
                        2'd1: vb_reg[q_head.idx] <= q_head.wdata;
                        default: vc_reg[q_head.idx] <= q_head.wdata;
                    endcase
                end
            end else if (m_tready) begin
                m_tvalid <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (q_valid && q_head.kind == K_RUN) begin
                        state_reg <= S_ELEM;
                        i_reg <= '0;
                    end
                end
                S_ELEM: begin
                    // Multiplies take the product registered in this state, in the next state S_DIV.
                    if (q_head.op == OP_DIV) begin
                        if (b_el == 32'd0) begin
                            vc_reg[i_reg] <= 32'd0;
                            i_reg <= i_reg + 1'b1;
                            if (last) begin
                                state_reg <= S_DONE;
                            end
                        end else begin
                            state_reg <= S_DIV;
                        end
                    end else begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (q_head.op != OP_DIV || div_done) begin
                        vc_reg[i_reg] <= (q_head.op == OP_DIV) ? div_q : res;
                        i_reg <= i_reg + 1'b1;
                        state_reg <= last ? S_DONE : S_ELEM;
                    end
                end
                S_DONE: begin
                    if (q_pop) begin
                        state_reg <= S_IDLE;
                        ctrl_reg <= '0;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `VARD_ASSERT(a_run_pop, aclk, aresetn, (q_pop && q_head.kind == K_RUN) |-> state_reg == S_DONE, "run popped early")
    `VARD_ASSERT(a_out_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> m_tvalid, "result dropped")
    `VARD_ASSERT(a_busy_valid, aclk, aresetn, (state_reg != S_IDLE) |-> q_valid, "run without command")
endmodule

// ===== sim/vector_alu_register_device_core_test.sv =====
// Self-checking testbench for the vector ALU register device core: register accesses,
// vector opcodes and error statuses against a local prediction. Depends on vard_pkg
// and vector_alu_register_device_core.
`timescale 1ns / 100ps

module vector_alu_register_device_core_test;
    import vard_pkg::*;

    typedef struct packed {
        logic       be;
        logic [3:0] wid;
        logic [3:0] len;
        logic [31:0] wdata;
        logic [11:0] addr;
        logic [1:0] req;
    } access_t;

    typedef struct {
        logic [31:0] rdata;
        status_t     status;
    } reply_t;

    localparam logic [1:0] REQ_OTHER = 2'd2;
    localparam logic [1:0] REQ_OTHER3 = 2'd3;
    localparam logic [11:0] CTRL_ADDR = 12'h000;
    localparam int LIMIT = 400000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [55:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [39:0] m_tdata;

    access_t pending_items[$];
    reply_t  expected_replies[$];
    logic [31:0] vec_a[WORDS];
    logic [31:0] vec_b[WORDS];
    logic [31:0] vec_c[WORDS];
    logic [31:0] ctrl_word;
    int errors = 0;
    int cycles = 0;
    int hold_off = 0;
    int sender_pause = 0;
    bit calm = 1'b0;
    bit in_fire = 1'b0;

    vector_alu_register_device_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic reply_t predict_access(access_t it);
        reply_t r;
        logic [31:0] v;
        logic hit;
        logic [3:0] k;
        r.rdata = '0;
        r.status = ST_OK;
        v = '0;
        hit = 1'b1;
        k = '0;
        if (it.be) begin
            r.status = ST_BYTE_ENABLE;
        end else if (it.len > MAX_BYTES || it.wid < it.len) begin
            r.status = ST_BURST;
        end else if (it.req == REQ_READ || it.req == REQ_WRITE) begin
            if (it.addr >= BASE_A && it.addr < BASE_B) k = 4'((it.addr - BASE_A) >> 2);
            else if (it.addr >= BASE_B && it.addr < BASE_C) k = 4'((it.addr - BASE_B) >> 2);
            else if (it.addr >= BASE_C && it.addr < END_C) k = 4'((it.addr - BASE_C) >> 2);
            else if (it.addr != CTRL_ADDR) hit = 1'b0;
            if (!hit) begin
                r.status = ST_ADDRESS;
            end else if (it.req == REQ_READ) begin
                if (it.addr == CTRL_ADDR) v = ctrl_word;
                else if (it.addr < BASE_B) v = vec_a[k];
                else if (it.addr < BASE_C) v = vec_b[k];
                else v = vec_c[k];
                r.rdata = (it.len >= MAX_BYTES) ? v : v & ((32'd1 << (8 * it.len)) - 1);
            end else if (it.addr == CTRL_ADDR) begin
                ctrl_word = it.wdata;
                if (it.wdata >= OP_ADD && it.wdata <= OP_MAC) begin
                    for (int i = 0; i < VECTOR_LENGTH; i++) begin
                        case (it.wdata[2:0])
                            OP_ADD: vec_c[i] = vec_a[i] + vec_b[i];
                            OP_SUB: vec_c[i] = vec_a[i] - vec_b[i];
                            OP_MUL: vec_c[i] = vec_a[i] * vec_b[i];
                            OP_DIV: vec_c[i] = (vec_b[i] != 0) ? vec_a[i] / vec_b[i] : '0;
                            default: vec_c[i] = vec_c[i] + vec_a[i] * vec_b[i];
                        endcase
                    end
                    ctrl_word = '0;
                end
            end else if (it.addr < BASE_B) begin
                vec_a[k] = it.wdata;
            end else if (it.addr < BASE_C) begin
                vec_b[k] = it.wdata;
            end else begin
                vec_c[k] = it.wdata;
            end
        end else begin
            r.status = ST_COMMAND;
        end
        return r;
    endfunction

    function automatic access_t make_access(logic [1:0] req, logic [11:0] addr,
                                            logic [31:0] wdata, logic [3:0] len);
        access_t it;
        it.req = req;
        it.addr = addr;
        it.wdata = wdata;
        it.len = len;
        it.wid = len;
        it.be = 1'b0;
        return it;
    endfunction

    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 7);
            3: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic access_t random_access();
        access_t it;
        int pick;
        pick = $urandom_range(0, 99);
        it = make_access(REQ_READ, 12'($urandom_range(0, 16'h00C3)), random_word(),
                         4'($urandom_range(0, 4)));
        it.wid = 4'($urandom_range(it.len, 15));
        if (pick < 35) begin
            it.req = REQ_WRITE;
            it.addr = 12'($urandom_range(BASE_A, END_C - 1));
        end else if (pick < 45) begin
            it.req = REQ_WRITE;
            it.addr = CTRL_ADDR;
            it.wdata = ($urandom_range(0, 4) != 0) ? 32'($urandom_range(OP_ADD, OP_MAC))
                                                   : random_word();
        end else if (pick < 85) begin
            it.req = REQ_READ;
            if ($urandom_range(0, 9) == 0) it.addr = CTRL_ADDR;
        end else if (pick < 89) begin
            it.addr = 12'($urandom_range(END_C, 4095));
            it.req = 2'($urandom_range(0, 1));
        end else if (pick < 92) begin
            it.req = 2'($urandom_range(REQ_OTHER, REQ_OTHER3));
        end else if (pick < 95) begin
            it.be = 1'b1;
            it.req = 2'($urandom);
            it.addr = 12'($urandom);
            it.len = 4'($urandom);
            it.wid = 4'($urandom);
        end else begin
            it.req = 2'($urandom);
            it.addr = 12'($urandom);
            it.len = 4'($urandom_range(0, 15));
            it.wid = 4'($urandom_range(0, 15));
        end
        return it;
    endfunction

    always @(negedge aclk) begin
        if (aresetn) begin
            if (hold_off > 0) hold_off <= hold_off - 1;
            m_tready <= (hold_off <= 1) && (calm || $urandom_range(0, 99) >= 31);
        end
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || in_fire) begin
                if (pending_items.size() > 0 && sender_pause == 0
                        && (calm || $urandom_range(0, 99) >= 31)) begin
                    s_tdata <= {1'b0, pending_items.pop_front()};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        reply_t exp_r;
        if (aresetn) begin
            cycles <= cycles + 1;
            in_fire <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                expected_replies.push_back(predict_access(access_t'(s_tdata[54:0])));
            end
            if (m_tvalid && m_tready) begin
                if (expected_replies.size() == 0) begin
                    $display("%0t: unexpected item rdata=%h status=%0d", $time,
                             m_tdata[31:0], m_tdata[34:32]);
                    errors <= errors + 1;
                end else begin
                    exp_r = expected_replies.pop_front();
                    if (m_tdata[31:0] !== exp_r.rdata || m_tdata[34:32] !== exp_r.status) begin
                        $display("%0t: mismatch expected rdata=%h status=%0d actual rdata=%h status=%0d",
                                 $time, exp_r.rdata, exp_r.status, m_tdata[31:0], m_tdata[34:32]);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

    initial begin
        access_t it;
        for (int i = 0; i < WORDS; i++) begin
            vec_a[i] = '0;
            vec_b[i] = '0;
            vec_c[i] = '0;
        end
        ctrl_word = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        pending_items.push_back(make_access(REQ_READ, BASE_C, '0, 4'd4));
        pending_items.push_back(make_access(REQ_WRITE, BASE_A, 32'hFFFF_FFFF, 4'd4));
        pending_items.push_back(make_access(REQ_WRITE, 12'h047, 32'h0000_0003, 4'd1));
        pending_items.push_back(make_access(REQ_WRITE, 12'h005, 32'h8765_4321, 4'd0));
        pending_items.push_back(make_access(REQ_READ, BASE_A, '0, 4'd0));
        pending_items.push_back(make_access(REQ_READ, BASE_A, '0, 4'd2));
        pending_items.push_back(make_access(REQ_READ, 12'h0C3, '0, 4'd3));
        for (int op = OP_ADD; op <= OP_MAC; op++) begin
            pending_items.push_back(make_access(REQ_WRITE, CTRL_ADDR, 32'(op), 4'd4));
            pending_items.push_back(make_access(REQ_READ, BASE_C, '0, 4'd4));
        end
        pending_items.push_back(make_access(REQ_WRITE, CTRL_ADDR, 32'hFFFF_FFF9, 4'd4));
        pending_items.push_back(make_access(REQ_READ, CTRL_ADDR, '0, 4'd4));
        pending_items.push_back(make_access(REQ_WRITE, END_C, 32'h1, 4'd4));
        pending_items.push_back(make_access(REQ_READ, 12'hFFF, '0, 4'd4));
        pending_items.push_back(make_access(REQ_OTHER, BASE_A, '0, 4'd4));
        pending_items.push_back(make_access(REQ_OTHER3, 12'hFFF, '0, 4'd4));
        it = make_access(REQ_READ, BASE_A, '0, 4'd8);
        pending_items.push_back(it);
        it.len = 4'd3;
        it.wid = 4'd2;
        pending_items.push_back(it);
        it.be = 1'b1;
        it.wid = 4'hF;
        pending_items.push_back(it);

        for (int i = 0; i < 1830; i++) pending_items.push_back(random_access());

        wait (pending_items.size() < 1500);
        @(negedge aclk);
        hold_off <= 300;
        wait (pending_items.size() < 1200);
        @(negedge aclk);
        sender_pause <= 1;
        wait (!s_tvalid && expected_replies.size() == 0);
        @(negedge aclk);
        sender_pause <= 0;
        calm <= 1'b1;
        wait (pending_items.size() < 900);
        @(negedge aclk);
        calm <= 1'b0;
        wait (pending_items.size() == 0 && !s_tvalid && expected_replies.size() == 0);
        repeat (700) @(posedge aclk);
        if (errors == 0 && expected_replies.size() == 0 && !m_tvalid) begin
            $display("PASS vector_alu_register_device_core");
        end else begin
            $display("FAIL vector_alu_register_device_core");
        end
        $finish;
    end

    initial begin
        wait (cycles >= LIMIT);
        $display("FAIL vector_alu_register_device_core");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/vard_pkg.sv
hw/rtl/vard_front.sv
hw/rtl/vard_div.sv
hw/rtl/vard_back.sv
hw/rtl/vector_alu_register_device_core.sv
sim/vector_alu_register_device_core_test.sv
